// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the matrix product block.
// Depends on nothing; the assertions compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("property violated");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: hw/rtl/mm4_pkg.sv
// Shared constants and command/status types of the fixed-point matrix product.
// Used by mm4_ctrl, mm4_dp and matrix_multiply_4x4; depends on nothing.
package mm4_pkg;

  localparam int unsigned DATA_W            = 32;
  localparam int unsigned IDX_OUT_W         = 2;
  localparam int unsigned DIM_DEFAULT       = 4;
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;       // write element_i into a matrix store
    logic wr_sel_b;    // 0: left matrix, 1: right matrix
    logic rd_en;       // read one pair of operands
    logic rd_first;    // first product of a result element
    logic rd_last;     // last product of a result element
    logic final_cell;  // result element is the last of the matrix
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;   // products still in flight or waiting for the output
    logic out_free;    // output register empty or taken this cycle
  } status_t;

endpackage

// File: hw/rtl/mm4_ctrl.sv
// Controller of the matrix product: load sequencing and operand address walk.
// Depends on mm4_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mm4_ctrl #(
  parameter int unsigned DIM = mm4_pkg::DIM_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  mm4_pkg::status_t                   status_i,
  output mm4_pkg::cmd_t                      cmd_o,
  output logic [$clog2(DIM*DIM)-1:0]         wr_addr_o,
  output logic [$clog2(DIM*DIM)-1:0]         rd_a_addr_o,
  output logic [$clog2(DIM*DIM)-1:0]         rd_b_addr_o,
  output logic [$clog2(DIM)-1:0]             row_o,
  output logic [$clog2(DIM)-1:0]             col_o
);

  localparam int unsigned Cells = DIM * DIM;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned IdxW  = $clog2(DIM);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] wr_cnt_q;
  logic             wr_sel_b_q;
  logic [IdxW-1:0]  row_q;
  logic [IdxW-1:0]  col_q;
  logic [IdxW-1:0]  k_q;
  logic [AddrW-1:0] row_base_q;
  logic [AddrW-1:0] a_addr_q;
  logic [AddrW-1:0] b_addr_q;
  logic             final_cell;

  assign final_cell = (row_q == IdxW'(DIM - 1)) && (col_q == IdxW'(DIM - 1));

  assign in_stall_o        = (state_q != ST_LOAD);
  assign cmd_o.wr_en       = (state_q == ST_LOAD) && in_valid_i;
  assign cmd_o.wr_sel_b    = wr_sel_b_q;
  assign cmd_o.rd_en       = (state_q == ST_ISSUE);
  assign cmd_o.rd_first    = (k_q == '0);
  assign cmd_o.rd_last     = (k_q == IdxW'(DIM - 1));
  assign cmd_o.final_cell  = final_cell;
  assign wr_addr_o         = wr_cnt_q;
  assign rd_a_addr_o       = a_addr_q;
  assign rd_b_addr_o       = b_addr_q;
  assign row_o             = row_q;
  assign col_o             = col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      wr_cnt_q   <= '0;
      wr_sel_b_q <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      k_q        <= '0;
      row_base_q <= '0;
      a_addr_q   <= '0;
      b_addr_q   <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_valid_i) begin
            if (wr_cnt_q == AddrW'(Cells - 1)) begin
              wr_cnt_q <= '0;
              if (wr_sel_b_q) begin
                wr_sel_b_q <= 1'b0;
                row_q      <= '0;
                col_q      <= '0;
                k_q        <= '0;
                row_base_q <= '0;
                a_addr_q   <= '0;
                b_addr_q   <= '0;
                state_q    <= ST_ISSUE;
              end else begin
                wr_sel_b_q <= 1'b1;
              end
            end else begin
              wr_cnt_q <= wr_cnt_q + AddrW'(1);
            end
          end
        end
        ST_ISSUE: begin
          // Walk along a row of the left matrix and down a column of the right.
          a_addr_q <= a_addr_q + AddrW'(1);
          b_addr_q <= b_addr_q + AddrW'(DIM);
          if (k_q == IdxW'(DIM - 1)) begin
            k_q     <= '0;
            state_q <= ST_WAIT;
          end else begin
            k_q <= k_q + IdxW'(1);
          end
        end
        ST_WAIT: begin
          // The next element, or the next load after the last one, starts only
          // once the output register can take a new result.
          if (!status_i.pipe_busy && status_i.out_free) begin
            if (final_cell) begin
              state_q <= ST_LOAD;
            end else begin
              state_q <= ST_ISSUE;
              if (col_q == IdxW'(DIM - 1)) begin
                col_q      <= '0;
                row_q      <= row_q + IdxW'(1);
                row_base_q <= row_base_q + AddrW'(DIM);
                a_addr_q   <= row_base_q + AddrW'(DIM);
                b_addr_q   <= '0;
              end else begin
                col_q    <= col_q + IdxW'(1);
                a_addr_q <= row_base_q;
                b_addr_q <= AddrW'(col_q + IdxW'(1));
              end
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  `ASSERT_PROP(a_load_cnt_idle, clk_i, rst_ni, (state_q != ST_LOAD) |-> ((wr_cnt_q == '0) && !wr_sel_b_q))
  `ASSERT_PROP(a_issue_starts_empty, clk_i, rst_ni, ((state_q == ST_ISSUE) && (k_q == '0)) |-> !status_i.pipe_busy)

endmodule

// File: hw/rtl/mm4_dp.sv
// Datapath of the matrix product: operand stores, multiplier, accumulator,
// saturation and output register. Depends on mm4_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mm4_dp #(
  parameter int unsigned DIM       = mm4_pkg::DIM_DEFAULT,
  parameter int unsigned FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic signed [mm4_pkg::DATA_W-1:0]      element_i,
  input  mm4_pkg::cmd_t                          cmd_i,
  input  logic [$clog2(DIM*DIM)-1:0]             wr_addr_i,
  input  logic [$clog2(DIM*DIM)-1:0]             rd_a_addr_i,
  input  logic [$clog2(DIM*DIM)-1:0]             rd_b_addr_i,
  input  logic [$clog2(DIM)-1:0]                 row_i,
  input  logic [$clog2(DIM)-1:0]                 col_i,
  output mm4_pkg::status_t                       status_o,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic signed [mm4_pkg::DATA_W-1:0]      product_element_o,
  output logic [mm4_pkg::IDX_OUT_W-1:0]          row_o,
  output logic [mm4_pkg::IDX_OUT_W-1:0]          column_o,
  output logic                                   saturated_o,
  output logic                                   last_o
);

  localparam int unsigned Cells   = DIM * DIM;
  localparam int unsigned IdxW    = $clog2(DIM);
  localparam int unsigned DataW   = mm4_pkg::DATA_W;
  localparam int unsigned IdxOutW = mm4_pkg::IDX_OUT_W;
  localparam int unsigned ProdW   = 2 * DataW;
  // A sum of DIM full products needs clog2(DIM) bits of headroom.
  localparam int unsigned AccW    = ProdW + $clog2(DIM);

  logic signed [DataW-1:0] a_mem [Cells];
  logic signed [DataW-1:0] b_mem [Cells];

  logic signed [DataW-1:0] a_rd_q;
  logic signed [DataW-1:0] b_rd_q;
  logic                    s1_v_q, s1_first_q, s1_last_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    s2_v_q, s2_first_q, s2_last_q;
  logic signed [AccW-1:0]  acc_q;
  logic                    acc_done_q;
  logic [IdxW-1:0]         tag_row_q;
  logic [IdxW-1:0]         tag_col_q;
  logic                    tag_final_q;

  logic                    out_valid_q;
  logic signed [DataW-1:0] out_data_q;
  logic [IdxW-1:0]         out_row_q;
  logic [IdxW-1:0]         out_col_q;
  logic                    out_sat_q;
  logic                    out_last_q;

  logic signed [AccW-1:0]  shifted;
  logic                    pos_ovf;
  logic                    neg_ovf;
  logic signed [DataW-1:0] sat_data;

  // Operand stores and registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !cmd_i.wr_sel_b) begin
      a_mem[wr_addr_i] <= element_i;
    end
    if (cmd_i.wr_en && cmd_i.wr_sel_b) begin
      b_mem[wr_addr_i] <= element_i;
    end
    if (cmd_i.rd_en) begin
      a_rd_q <= a_mem[rd_a_addr_i];
      b_rd_q <= b_mem[rd_b_addr_i];
    end
    if (cmd_i.rd_en && cmd_i.rd_first) begin
      tag_row_q   <= row_i;
      tag_col_q   <= col_i;
      tag_final_q <= cmd_i.final_cell;
    end
    if (s1_v_q) begin
      prod_q <= a_rd_q * b_rd_q;
    end
    if (s2_v_q) begin
      acc_q <= s2_first_q ? AccW'(prod_q) : acc_q + AccW'(prod_q);
    end
    if (acc_done_q) begin
      out_data_q <= sat_data;
      out_row_q  <= tag_row_q;
      out_col_q  <= tag_col_q;
      out_sat_q  <= pos_ovf || neg_ovf;
      out_last_q <= tag_final_q;
    end
  end

  // Floor by the fraction width, then clip to the 32-bit range.
  assign shifted  = acc_q >>> FRAC_BITS;
  assign pos_ovf  = !shifted[AccW-1] && (|shifted[AccW-2:DataW-1]);
  assign neg_ovf  = shifted[AccW-1] && !(&shifted[AccW-2:DataW-1]);

  always_comb begin
    if (pos_ovf) begin
      sat_data = {1'b0, {(DataW - 1){1'b1}}};
    end else if (neg_ovf) begin
      sat_data = {1'b1, {(DataW - 1){1'b0}}};
    end else begin
      sat_data = shifted[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s1_first_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_v_q      <= 1'b0;
      s2_first_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      acc_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_v_q     <= cmd_i.rd_en;
      s1_first_q <= cmd_i.rd_first;
      s1_last_q  <= cmd_i.rd_last;
      s2_v_q     <= s1_v_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      acc_done_q <= s2_v_q && s2_last_q;
      if (acc_done_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.pipe_busy = s1_v_q || s2_v_q || acc_done_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign product_element_o = out_data_q;
  assign row_o             = IdxOutW'(out_row_q);
  assign column_o          = IdxOutW'(out_col_q);
  assign saturated_o       = out_sat_q;
  assign last_o            = out_last_q;

  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, acc_done_q && out_valid_q && out_stall_i)
  `ASSERT_PROP(a_last_is_corner, clk_i, rst_ni, (out_valid_q && out_last_q) |-> ((out_row_q == IdxW'(DIM - 1)) && (out_col_q == IdxW'(DIM - 1))))

endmodule

// File: hw/rtl/matrix_multiply_4x4.sv
// Top level of the streaming fixed-point matrix product A times B.
// Depends on mm4_pkg, mm4_ctrl and mm4_dp.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    element_i
//   out      output     out_valid_o / out_stall_i  product_element_o, row_o,
//                                                  column_o, saturated_o, last_o
//
// Loading takes one element per cycle while in_valid_i is high, left matrix first.
// Each result element then takes DIM operand reads through the single read
// port of each store, then read, multiply, accumulate and output registers.
// Reset clears the load count and control state; the stores are not cleared.
// A stalled output holds the next result element, or the next load after the
// last element, from starting.
module matrix_multiply_4x4 #(
  parameter int unsigned DIM       = mm4_pkg::DIM_DEFAULT,
  parameter int unsigned FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [mm4_pkg::DATA_W-1:0]   element_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mm4_pkg::DATA_W-1:0]   product_element_o,
  output logic [mm4_pkg::IDX_OUT_W-1:0]       row_o,
  output logic [mm4_pkg::IDX_OUT_W-1:0]       column_o,
  output logic                                saturated_o,
  output logic                                last_o
);

  localparam int unsigned AddrW = $clog2(DIM * DIM);
  localparam int unsigned IdxW  = $clog2(DIM);

  mm4_pkg::cmd_t    cmd;
  mm4_pkg::status_t status;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_a_addr;
  logic [AddrW-1:0] rd_b_addr;
  logic [IdxW-1:0]  row_idx;
  logic [IdxW-1:0]  col_idx;

  mm4_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .rd_a_addr_o (rd_a_addr),
    .rd_b_addr_o (rd_b_addr),
    .row_o       (row_idx),
    .col_o       (col_idx)
  );

  mm4_dp #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .element_i         (element_i),
    .cmd_i             (cmd),
    .wr_addr_i         (wr_addr),
    .rd_a_addr_i       (rd_a_addr),
    .rd_b_addr_i       (rd_b_addr),
    .row_i             (row_idx),
    .col_i             (col_idx),
    .status_o          (status),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .product_element_o (product_element_o),
    .row_o             (row_o),
    .column_o          (column_o),
    .saturated_o       (saturated_o),
    .last_o            (last_o)
  );

endmodule

// File: verif/matrix_multiply_4x4_tb.sv
// Testbench for matrix_multiply_4x4: streams pairs of Q16.16 matrices and checks
// every product element against an in-bench fixed-point predictor.
// Depends on mm4_pkg and the matrix_multiply_4x4 RTL; reads no files.
module matrix_multiply_4x4_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DATA_W    = mm4_pkg::DATA_W;
  localparam int unsigned IDX_OUT_W = mm4_pkg::IDX_OUT_W;
  localparam int unsigned DIM      = mm4_pkg::DIM_DEFAULT;
  localparam int unsigned FRAC     = mm4_pkg::FRAC_BITS_DEFAULT;
  localparam int unsigned CELLS    = DIM * DIM;
  localparam int unsigned SET_SIZE = 2 * CELLS;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned PRINT_CAP   = 20;

  localparam logic signed [65:0] Q_MAX = (66'sd1 <<< 31) - 66'sd1;
  localparam logic signed [65:0] Q_MIN = -(66'sd1 <<< 31);

  typedef struct packed {
    logic signed [DATA_W-1:0]  value;
    logic [IDX_OUT_W-1:0]      row;
    logic [IDX_OUT_W-1:0]      column;
    logic                      saturated;
    logic                      last;
  } product_t;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic signed [DATA_W-1:0]    element_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [DATA_W-1:0]    product_element_o;
  logic [IDX_OUT_W-1:0]        row_o;
  logic [IDX_OUT_W-1:0]        column_o;
  logic                        saturated_o;
  logic                        last_o;

  // Predictor state: both operand matrices and the position in the load.
  logic signed [DATA_W-1:0]    left_store [CELLS];
  logic signed [DATA_W-1:0]    right_store [CELLS];
  int unsigned                 load_position = 0;
  product_t                    pending_products [$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned elements_sent = 0;
  int unsigned products_checked = 0;
  int unsigned clipped_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  matrix_multiply_4x4 DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .element_i         (element_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .product_element_o (product_element_o),
    .row_o             (row_o),
    .column_o          (column_o),
    .saturated_o       (saturated_o),
    .last_o            (last_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Takes one accepted element; once both matrices are complete, queues the
  // full product in row-major order. Products are exact, the sum is floored
  // by an arithmetic shift and then clipped to 32 bits.
  function automatic void load_element(input logic signed [DATA_W-1:0] value);
    logic signed [65:0] acc;
    logic signed [65:0] floored;
    product_t           p;
    if (load_position < CELLS) left_store[load_position] = value;
    else right_store[load_position - CELLS] = value;
    load_position++;
    if (load_position == SET_SIZE) begin
      load_position = 0;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          acc = '0;
          for (int k = 0; k < DIM; k++) begin
            acc = acc + left_store[r * DIM + k] * right_store[k * DIM + c];
          end
          floored = acc >>> FRAC;
          p.saturated = 1'b1;
          if (floored > Q_MAX) p.value = Q_MAX[DATA_W-1:0];
          else if (floored < Q_MIN) p.value = Q_MIN[DATA_W-1:0];
          else begin
            p.value = floored[DATA_W-1:0];
            p.saturated = 1'b0;
          end
          p.row    = r[IDX_OUT_W-1:0];
          p.column = c[IDX_OUT_W-1:0];
          p.last   = (r == DIM - 1) && (c == DIM - 1);
          pending_products.push_back(p);
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] MISMATCH %s: got %h, want %h (result %0d)", $realtime, what, got,
               want, products_checked);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : check_products
    product_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_products.size() == 0) begin
        report_mismatch("result with no request pending", product_element_o, '0);
      end else begin
        want = pending_products.pop_front();
        if (product_element_o !== want.value)
          report_mismatch("product_element", product_element_o, want.value);
        if (row_o !== want.row)
          report_mismatch("row", DATA_W'(row_o), DATA_W'(want.row));
        if (column_o !== want.column)
          report_mismatch("column", DATA_W'(column_o), DATA_W'(want.column));
        if (saturated_o !== want.saturated)
          report_mismatch("saturated", DATA_W'(saturated_o), DATA_W'(want.saturated));
        if (last_o !== want.last)
          report_mismatch("last", DATA_W'(last_o), DATA_W'(want.last));
        if (want.saturated) clipped_seen++;
        products_checked++;
      end
    end
  end

  // Counts cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_element(input logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    element_i  <= value;
    do @(posedge clk_i); while (in_stall_o);
    load_element(value);
    elements_sent++;
  endtask

  task automatic wait_for_products;
    in_valid_i <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk_i);
  endtask

  // Mostly values near unity so sums stay in range, with full-width noise and
  // the corner values mixed in.
  function automatic logic signed [DATA_W-1:0] random_element();
    logic [DATA_W-1:0] corners [7] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                       32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000,
                                       32'hFFFF_0000};
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
      4, 5:       return $urandom;
      6:          return corners[$urandom_range(6)];
      7, 8:       return $urandom_range(32'h0200_0000) - 32'h0100_0000;
      default:    return -$urandom_range(32'h0000_FFFF, 1);
    endcase
  endfunction

  task automatic send_random_sets(input int unsigned sets);
    repeat (sets * SET_SIZE) send_element(random_element());
  endtask

  // One hand-built pair: rows of A at the largest and smallest values clip in
  // both directions, a row of -1 LSB shows flooring toward minus infinity, and
  // a unit row passes the extremes of B through without clipping.
  task automatic test_directed_extremes;
    logic [DATA_W-1:0] pair [SET_SIZE] = '{
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
      32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0001_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_8000};
    idle_pct  = 0;
    stall_pct = 0;
    foreach (pair[i]) send_element(pair[i]);
    wait_for_products();
  endtask

  task automatic test_no_idling;
    idle_pct  = 0;
    stall_pct = 0;
    send_random_sets(1);
    wait_for_products();
  endtask

  task automatic test_sender_gaps;
    idle_pct  = 88;
    stall_pct = 0;
    send_random_sets(1);
    wait_for_products();
  endtask

  task automatic test_receiver_stalls;
    idle_pct  = 0;
    stall_pct = 88;
    send_random_sets(1);
    wait_for_products();
  endtask

  task automatic test_both_sides_idle;
    idle_pct  = 25;
    stall_pct = 25;
    send_random_sets(2);
    wait_for_products();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();

    in_valid_i <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Loaded %0d elements; checked %0d product elements, %0d of them clipped,",
             elements_sent, products_checked, clipped_seen);
    $display("under free-running, sender-gap, receiver-stall and mixed idling.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
